// ----- rtl/rctc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rctc_pkg;

  localparam int unsigned LOG_TABLE_ENTRIES_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF         = 16;

  localparam int unsigned CNT_W   = 21;
  localparam int unsigned OHM_W   = 16;
  localparam int unsigned BETA_W  = 14;
  localparam int unsigned NK_W    = 9;
  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned XW      = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic signed [32:0] LN2_Q32 = 33'sd2977044472;

  localparam int unsigned T_OFS = 2730;
  localparam int unsigned T_HI  = 4230;
  localparam int unsigned T_LO  = 2180;
  localparam logic signed [TEMP_W-1:0] T_MAX = 12'sd1500;
  localparam logic signed [TEMP_W-1:0] T_MIN = -12'sd550;

  typedef enum logic [2:0] {
    REG_TIMEOUT  = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_SPAN_US  = 3'd2,
    REG_BASE     = 3'd3,
    REG_SPAN_OHM = 3'd4,
    REG_NOM_OHM  = 3'd5,
    REG_BETA     = 3'd6,
    REG_NOM_K    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CNT_W-1:0]  timeout_us;
    logic [CNT_W-1:0]  offset_us;
    logic [CNT_W-1:0]  span_us;
    logic [OHM_W-1:0]  base_ohms;
    logic [OHM_W-1:0]  span_ohms;
    logic [OHM_W-1:0]  nominal_ohms;
    logic [BETA_W-1:0] beta_kelvin;
    logic [NK_W-1:0]   nominal_kelvin;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ITEM,
    OP_MUL,
    OP_DIV1,
    OP_RES,
    OP_NORM,
    OP_IDX,
    OP_IMUL,
    OP_SUM_R,
    OP_SUM_N,
    OP_LOAD_N,
    OP_LN,
    OP_DEN,
    OP_DSUM,
    OP_DIV2,
    OP_FIN
  } dp_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV1,
    ST_DIV1_W,
    ST_RES,
    ST_NORM,
    ST_IDX,
    ST_IMUL,
    ST_ISUM,
    ST_LOAD_N,
    ST_LN,
    ST_DEN,
    ST_DSUM,
    ST_DIV2,
    ST_DIV2_W,
    ST_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic item_done;
    logic norm_done;
    logic div_busy;
    logic den_bad;
  } dp_status_t;

  // log2(1 + i/2^k) in Qf by repeated squaring of a Q30 mantissa
  function automatic logic [31:0] log_entry(input int unsigned i, input int unsigned k,
                                            input int unsigned f);
    logic [63:0] m;
    logic [31:0] v;
    m = (64'(1) << 30) + (64'(i) << (30 - k));
    v = '0;
    if (m >= (64'(1) << 31)) begin
      m = m >> 1;
      v = v + (32'(1) << f);
    end
    for (int b = int'(f) - 1; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'(1) << 31)) begin
        m = m >> 1;
        v = v + (32'(1) << b);
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rctc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rctc_in_if;
  logic valid;
  logic ready;
  logic command;
  logic sense_asserted;
  modport source (output valid, output command, output sense_asserted, input ready);
  modport sink (input valid, input command, input sense_asserted, output ready);
endinterface

interface rctc_out_if;
  logic                valid;
  logic                ready;
  logic                drive_asserted;
  logic                done_res;
  logic                timed_out;
  logic [20:0]         elapsed_us;
  logic signed [11:0]  temperature_tenths;
  logic                out_of_range;
  modport source (output valid, output drive_asserted, output done_res, output timed_out,
                  output elapsed_us, output temperature_tenths, output out_of_range,
                  input ready);
  modport sink (input valid, input drive_asserted, input done_res, input timed_out,
                input elapsed_us, input temperature_tenths, input out_of_range,
                output ready);
endinterface
`default_nettype wire

// ----- rtl/rctc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rctc_div #(
  parameter int unsigned NW  = 43,
  parameter int unsigned DVW = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [NW-1:0]  dividend_i,
  input  wire logic [DVW-1:0] divisor_i,
  output logic                busy_o,
  output logic [NW-1:0]       quot_o,
  output logic                rem_nz_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] dvd_q;
  logic [DVW-1:0] rem_q, dsr_q;
  logic [DVW:0]  trial;
  logic          qbit;

  always_comb begin
    trial = {rem_q, dvd_q[NW-1]};
    qbit  = (trial >= {1'b0, dsr_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(NW);
    end else if (busy_q) begin
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NW-2:0], qbit};
      rem_q <= qbit ? DVW'(trial - {1'b0, dsr_q}) : trial[DVW-1:0];
    end
  end

  assign busy_o   = busy_q;
  assign quot_o   = dvd_q;
  assign rem_nz_o = |rem_q;
endmodule
`default_nettype wire

// ----- rtl/rctc_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rctc_regs
  import rctc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);
  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_us     <= CNT_W'(500000);
      cfg_q.offset_us      <= CNT_W'(76300);
      cfg_q.span_us        <= CNT_W'(218300);
      cfg_q.base_ohms      <= OHM_W'(2400);
      cfg_q.span_ohms      <= OHM_W'(7800);
      cfg_q.nominal_ohms   <= OHM_W'(10000);
      cfg_q.beta_kelvin    <= BETA_W'(4300);
      cfg_q.nominal_kelvin <= NK_W'(298);
    end else if (wr) begin
      case (idx)
        REG_TIMEOUT:  cfg_q.timeout_us     <= pwdata[CNT_W-1:0];
        REG_OFFSET:   cfg_q.offset_us      <= pwdata[CNT_W-1:0];
        REG_SPAN_US:  cfg_q.span_us        <= pwdata[CNT_W-1:0];
        REG_BASE:     cfg_q.base_ohms      <= pwdata[OHM_W-1:0];
        REG_SPAN_OHM: cfg_q.span_ohms      <= pwdata[OHM_W-1:0];
        REG_NOM_OHM:  cfg_q.nominal_ohms   <= pwdata[OHM_W-1:0];
        REG_BETA:     cfg_q.beta_kelvin    <= pwdata[BETA_W-1:0];
        REG_NOM_K:    cfg_q.nominal_kelvin <= pwdata[NK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_TIMEOUT:  prdata = 32'(cfg_q.timeout_us);
      REG_OFFSET:   prdata = 32'(cfg_q.offset_us);
      REG_SPAN_US:  prdata = 32'(cfg_q.span_us);
      REG_BASE:     prdata = 32'(cfg_q.base_ohms);
      REG_SPAN_OHM: prdata = 32'(cfg_q.span_ohms);
      REG_NOM_OHM:  prdata = 32'(cfg_q.nominal_ohms);
      REG_BETA:     prdata = 32'(cfg_q.beta_kelvin);
      REG_NOM_K:    prdata = 32'(cfg_q.nominal_kelvin);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
endmodule
`default_nettype wire

// ----- rtl/rctc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rctc_dp
  import rctc_pkg::*;
#(
  parameter int unsigned LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF,
  parameter int unsigned FRAC_BITS         = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_status_t              status_o,
  input  wire logic               command_i,
  input  wire logic               sense_i,
  output logic                    drive_o,
  output logic                    done_o,
  output logic                    tmo_o,
  output logic [CNT_W-1:0]        elapsed_o,
  output logic signed [TEMP_W-1:0] temp_o,
  output logic                    flag_o
);
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned K    = $clog2(LOG_TABLE_ENTRIES);
  localparam int unsigned RLW  = 30 - K;
  localparam int unsigned TW   = F + 1;
  localparam int unsigned LW   = F + 6;
  localparam int unsigned DFW  = LW + 1;
  localparam int unsigned LNPW = DFW + 33;
  localparam int unsigned LNW  = LNPW - 32;
  localparam int unsigned DMW  = LNW + 10;
  localparam int unsigned DW   = F + 17;
  localparam int unsigned DVW  = F + 16;
  localparam int unsigned NW   = (F + 27 > 38) ? F + 27 : 38;
  localparam int unsigned PW   = 39;
  localparam int unsigned RW   = 41;

  logic [TW-1:0] tab [0:LOG_TABLE_ENTRIES];
  for (genvar gi = 0; gi <= LOG_TABLE_ENTRIES; gi++) begin : g_tab
    localparam logic [31:0] ENTRY = log_entry(gi, K, F);
    assign tab[gi] = ENTRY[TW-1:0];
  end

  logic                     meas_q, tmo_q, flag_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic signed [PW-1:0]     prod_q;
  logic [XW-1:0]            x_q;
  logic [5:0]               e_q;
  logic [TW-1:0]            t0_q, dif_q;
  logic [RLW-1:0]           rl_q;
  logic [TW+RLW-1:0]        pm_q;
  logic [LW-1:0]            lr_q, ln_q;
  logic signed [LNPW-1:0]   lnp_q;
  logic signed [DMW-1:0]    dm_q;
  logic [BETA_W+NK_W-1:0]   bt_q;
  logic signed [DW-1:0]     den_q;
  logic [NW-1:0]            top_q;

  logic                     o_drive_q, o_done_q, o_tmo_q, o_flag_q;
  logic [CNT_W-1:0]         o_elapsed_q;
  logic signed [TEMP_W-1:0] o_temp_q;

  logic [CNT_W-1:0]         cnt_inc, cnt_nx;
  logic                     meas_nx, hit_tmo, item_done;
  logic signed [16:0]       span_s;
  logic signed [21:0]       cdiff;
  logic [PW-1:0]            pmag;
  logic [RW-1:0]            qmag;
  logic signed [RW-1:0]     qs, rsum;
  logic [29:0]              frac;
  logic [K-1:0]             idx;
  logic [TW-1:0]            t0, t1;
  logic signed [DFW-1:0]    ldif;
  logic signed [LNW-1:0]    lnv;
  logic [26:0]              tt;
  logic                     den_bad;

  logic                     div_start, div_busy, div_rnz;
  logic [NW-1:0]            div_dvd, div_quot;
  logic [DVW-1:0]           div_dsr;
  logic signed [TEMP_W-1:0] t_res;
  logic                     t_flag;

  always_comb begin
    cnt_inc   = (cnt_q != CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
    hit_tmo   = command_i & meas_q & ~sense_i & (cnt_inc >= cfg_i.timeout_us);
    item_done = command_i & meas_q & (sense_i | hit_tmo);
    meas_nx   = meas_q;
    cnt_nx    = cnt_q;
    if (!command_i) begin
      meas_nx = 1'b1;
      cnt_nx  = '0;
    end else if (meas_q) begin
      if (!sense_i) begin
        cnt_nx = cnt_inc;
      end
      if (item_done) begin
        meas_nx = 1'b0;
      end
    end
  end

  always_comb begin
    span_s = signed'({1'b0, cfg_i.span_ohms});
    cdiff  = signed'({1'b0, cnt_q}) - signed'({1'b0, cfg_i.offset_us});
    pmag   = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
    qmag   = RW'(div_quot[37:0]) + RW'(prod_q[PW-1] & div_rnz);
    qs     = prod_q[PW-1] ? -signed'(qmag) : signed'(qmag);
    rsum   = signed'(RW'(cfg_i.base_ohms)) + qs;
    frac   = x_q[XW-2 -: 30];
    idx    = frac[29 -: K];
    t0     = tab[{1'b0, idx}];
    t1     = tab[{1'b0, idx} + (K+1)'(1)];
    ldif   = signed'({1'b0, lr_q}) - signed'({1'b0, ln_q});
    lnv    = lnp_q[LNPW-1:32];
    tt     = 27'({bt_q, 3'b000}) + 27'({bt_q, 1'b0});
    den_bad = den_q[DW-1] | (den_q == '0);
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = NW'(pmag);
    div_dsr   = (cfg_i.span_us == '0) ? DVW'(1) : DVW'(cfg_i.span_us);
    if (cmd_i.op == OP_DIV1) begin
      div_start = 1'b1;
    end else if (cmd_i.op == OP_DIV2) begin
      div_start = ~den_bad;
      div_dvd   = top_q + NW'(den_q[DW-1:1]);
      div_dsr   = den_q[DVW-1:0];
    end
  end

  rctc_div #(
    .NW  (NW),
    .DVW (DVW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_nz_o   (div_rnz)
  );

  always_comb begin
    t_flag = 1'b0;
    t_res  = signed'(TEMP_W'(div_quot[12:0] - 13'(T_OFS)));
    if (den_bad || div_quot > NW'(T_HI)) begin
      t_flag = 1'b1;
      t_res  = T_MAX;
    end else if (div_quot < NW'(T_LO)) begin
      t_flag = 1'b1;
      t_res  = T_MIN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_q <= 1'b0;
      cnt_q  <= '0;
      temp_q <= '0;
    end else if (cmd_i.op == OP_ITEM) begin
      meas_q <= meas_nx;
      cnt_q  <= cnt_nx;
    end else if (cmd_i.op == OP_FIN) begin
      temp_q <= t_res;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ITEM: begin
        tmo_q  <= hit_tmo;
        flag_q <= 1'b0;
        if (!item_done) begin
          o_drive_q   <= meas_nx;
          o_done_q    <= 1'b0;
          o_tmo_q     <= 1'b0;
          o_elapsed_q <= cnt_nx;
          o_temp_q    <= temp_q;
          o_flag_q    <= 1'b0;
        end
      end
      OP_MUL: prod_q <= span_s * cdiff;
      OP_RES: begin
        e_q <= 6'(XW - 1);
        if (rsum < signed'(RW'(1))) begin
          x_q    <= XW'(1);
          flag_q <= 1'b1;
        end else begin
          x_q <= rsum[XW-1:0];
        end
      end
      OP_NORM: begin
        if (!x_q[XW-1]) begin
          x_q <= {x_q[XW-2:0], 1'b0};
          e_q <= e_q - 6'd1;
        end
      end
      OP_IDX: begin
        t0_q  <= t0;
        dif_q <= t1 - t0;
        rl_q  <= frac[RLW-1:0];
      end
      OP_IMUL: pm_q <= dif_q * rl_q;
      OP_SUM_R: lr_q <= {e_q, {F{1'b0}}} + LW'(t0_q) + LW'(pm_q >> RLW);
      OP_SUM_N: ln_q <= {e_q, {F{1'b0}}} + LW'(t0_q) + LW'(pm_q >> RLW);
      OP_LOAD_N: begin
        e_q <= 6'(XW - 1);
        x_q <= (cfg_i.nominal_ohms == '0) ? XW'(1) : XW'(cfg_i.nominal_ohms);
      end
      OP_LN: lnp_q <= ldif * LN2_Q32;
      OP_DEN: begin
        dm_q <= signed'({1'b0, cfg_i.nominal_kelvin}) * lnv;
        bt_q <= cfg_i.beta_kelvin * cfg_i.nominal_kelvin;
      end
      OP_DSUM: begin
        den_q <= signed'(DW'({cfg_i.beta_kelvin, {F{1'b0}}})) + DW'(dm_q);
        top_q <= NW'({tt, {F{1'b0}}});
      end
      OP_FIN: begin
        o_drive_q   <= meas_q;
        o_done_q    <= 1'b1;
        o_tmo_q     <= tmo_q;
        o_elapsed_q <= cnt_q;
        o_temp_q    <= t_res;
        o_flag_q    <= flag_q | t_flag;
      end
      default: ;
    endcase
  end

  assign status_o.item_done = item_done;
  assign status_o.norm_done = x_q[XW-1];
  assign status_o.div_busy  = div_busy;
  assign status_o.den_bad   = den_bad;

  assign drive_o   = o_drive_q;
  assign done_o    = o_done_q;
  assign tmo_o     = o_tmo_q;
  assign elapsed_o = o_elapsed_q;
  assign temp_o    = o_temp_q;
  assign flag_o    = o_flag_q;
endmodule
`default_nettype wire

// ----- rtl/rctc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rctc_ctrl
  import rctc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);
  ctrl_state_e state_q, state_d;
  logic        pass_q, pass_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free, beat;

  assign out_free = ~out_valid_q | out_ready_i;
  assign beat     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (beat && status_i.item_done) state_d = ST_MUL;
      ST_MUL:    state_d = ST_DIV1;
      ST_DIV1:   state_d = ST_DIV1_W;
      ST_DIV1_W: if (!status_i.div_busy) state_d = ST_RES;
      ST_RES:    state_d = ST_NORM;
      ST_NORM:   if (status_i.norm_done) state_d = ST_IDX;
      ST_IDX:    state_d = ST_IMUL;
      ST_IMUL:   state_d = ST_ISUM;
      ST_ISUM:   state_d = pass_q ? ST_LN : ST_LOAD_N;
      ST_LOAD_N: state_d = ST_NORM;
      ST_LN:     state_d = ST_DEN;
      ST_DEN:    state_d = ST_DSUM;
      ST_DSUM:   state_d = ST_DIV2;
      ST_DIV2:   state_d = status_i.den_bad ? ST_FIN : ST_DIV2_W;
      ST_DIV2_W: if (!status_i.div_busy) state_d = ST_FIN;
      ST_FIN:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    pass_d     = pass_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (beat) begin
          cmd_o.op = OP_ITEM;
          if (!status_i.item_done) begin
            out_valid_d = 1'b1;
          end
        end
      end
      ST_MUL:  cmd_o.op = OP_MUL;
      ST_DIV1: cmd_o.op = OP_DIV1;
      ST_RES: begin
        cmd_o.op = OP_RES;
        pass_d   = 1'b0;
      end
      ST_NORM: cmd_o.op = OP_NORM;
      ST_IDX:  cmd_o.op = OP_IDX;
      ST_IMUL: cmd_o.op = OP_IMUL;
      ST_ISUM: cmd_o.op = pass_q ? OP_SUM_N : OP_SUM_R;
      ST_LOAD_N: begin
        cmd_o.op = OP_LOAD_N;
        pass_d   = 1'b1;
      end
      ST_LN:   cmd_o.op = OP_LN;
      ST_DEN:  cmd_o.op = OP_DEN;
      ST_DSUM: cmd_o.op = OP_DSUM;
      ST_DIV2: cmd_o.op = OP_DIV2;
      ST_FIN: begin
        if (out_free) begin
          cmd_o.op    = OP_FIN;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=> out_valid_q)
    else $error("finished conversion not presented");
  a_done_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && beat && status_i.item_done) |=> (state_q == ST_MUL && !out_valid_q)
                                                           || state_q == ST_MUL)
    else $error("ending beat did not start conversion");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("input taken during conversion");
endmodule
`default_nettype wire

// ----- rtl/rc_thermistor_timing_converter.sv -----
// RC thermistor timing converter. A start beat (command 0) raises the drive line and
// clears the microsecond counter; each tick beat (command 1) counts while the sense line
// is low. Every input beat gives one output beat. Start beats, ticks that do not end a
// measurement and ticks while idle present their result in the cycle after the beat. A
// tick that ends a measurement (sense high or timeout reached) runs the resistance and
// temperature conversion: two passes of a shared restoring divider whose dividend is
// NW = max(38, FRAC_BITS+27) bits wide, two log2 passes, each with a normalising shift,
// plus multiply, add and hand-off steps. LOG_TABLE_ENTRIES must be a power of two.
// Registers sit at byte address 4*i on the APB port.
`timescale 1ns / 1ps
`default_nettype none
module rc_thermistor_timing_converter
  import rctc_pkg::*;
#(
  parameter int unsigned LOG_TABLE_ENTRIES = LOG_TABLE_ENTRIES_DEF,
  parameter int unsigned FRAC_BITS         = FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  rctc_in_if.sink                 in_i,
  rctc_out_if.source              out_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  rctc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rctc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rctc_dp #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES),
    .FRAC_BITS         (FRAC_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd),
    .status_o  (status),
    .command_i (in_i.command),
    .sense_i   (in_i.sense_asserted),
    .drive_o   (out_o.drive_asserted),
    .done_o    (out_o.done_res),
    .tmo_o     (out_o.timed_out),
    .elapsed_o (out_o.elapsed_us),
    .temp_o    (out_o.temperature_tenths),
    .flag_o    (out_o.out_of_range)
  );
endmodule
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import rctc_pkg::*;

  typedef struct packed {
    logic                     drive;
    logic                     done;
    logic                     tmo;
    logic [CNT_W-1:0]         elapsed;
    logic signed [TEMP_W-1:0] temp;
    logic                     oor;
  } meas_beat_t;

  typedef struct packed {
    logic       cmd;
    logic       sense;
    logic       known;
    meas_beat_t res;
  } steer_row_t;

  localparam int unsigned TICK  = 1;
  localparam int unsigned START = 0;
  localparam int unsigned NSTEER = 9;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rctc_in_if  in_bus ();
  rctc_out_if out_bus ();

  rc_thermistor_timing_converter uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state
  longint            log2_lut [0:256];
  logic [31:0]       shadow [8];
  logic              pr_meas;
  logic [CNT_W-1:0]  pr_count;
  logic signed [TEMP_W-1:0] pr_temp;
  int                reg_width [8] = '{21, 21, 21, 16, 16, 16, 14, 9};

  meas_beat_t        pending_beats [$];
  int                mismatches = 0;
  int                beats_seen = 0;
  int                dones_seen = 0;
  int                timeouts_seen = 0;
  int                saturated_seen = 0;
  int                items_sent = 0;
  bit                src_gaps = 1'b1;
  bit                snk_stalls = 1'b1;
  bit                hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void build_log2_lut();
    longint unsigned m;
    longint v;
    for (int i = 0; i <= 256; i++) begin
      m = (64'd1 << 30) + ((64'(i) << 30) / 256);
      v = 0;
      while (m >= (64'd1 << 31)) begin
        m = m >> 1;
        v = v + 65536;
      end
      for (int b = 15; b >= 0; b--) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          v = v + (64'sd1 << b);
        end
      end
      log2_lut[i] = v;
    end
  endfunction

  function automatic longint log2_q16(longint unsigned x);
    int e;
    longint unsigned f, p, rem, idx;
    longint d;
    if (x == 0) x = 1;
    e = 63;
    while (x[e] == 1'b0) e--;
    f = x - (64'd1 << e);
    f = (e >= 30) ? (f >> (e - 30)) : (f << (30 - e));
    p = f * 256;
    idx = p >> 30;
    if (idx >= 256) idx = 255;
    rem = p - (idx << 30);
    d = log2_lut[idx + 1] - log2_lut[idx];
    return (longint'(e) << 16) + log2_lut[idx] + ((d * longint'(rem)) >>> 30);
  endfunction

  function automatic logic signed [TEMP_W-1:0] temp_of_count(input logic [CNT_W-1:0] cnt,
                                                            output logic sat);
    longint span_us, num, q, r, lnv, den, top, t, beta, nk;
    longint unsigned nom;
    sat = 1'b0;
    span_us = (shadow[REG_SPAN_US] != 0) ? longint'(shadow[REG_SPAN_US]) : 1;
    num = longint'(shadow[REG_SPAN_OHM]) * (longint'(cnt) - longint'(shadow[REG_OFFSET]));
    nom = (shadow[REG_NOM_OHM] != 0) ? shadow[REG_NOM_OHM] : 1;
    beta = longint'(shadow[REG_BETA]);
    nk = longint'(shadow[REG_NOM_K]);
    if (num >= 0) q = num / span_us;
    else q = -((-num + span_us - 1) / span_us);
    r = longint'(shadow[REG_BASE]) + q;
    if (r < 1) begin
      r = 1;
      sat = 1'b1;
    end
    lnv = ((log2_q16(r) - log2_q16(nom)) * 64'sd2977044472) >>> 32;
    den = (beta << 16) + nk * lnv;
    if (den <= 0) begin
      sat = 1'b1;
      return T_MAX;
    end
    top = (64'sd10 * beta * nk) << 16;
    t = (top + den / 2) / den - 2730;
    if (t > 1500) begin
      sat = 1'b1;
      t = 1500;
    end else if (t < -550) begin
      sat = 1'b1;
      t = -550;
    end
    return TEMP_W'(t);
  endfunction

  function automatic meas_beat_t step_thermistor(input logic cmd, input logic sense);
    meas_beat_t b;
    logic sat;
    b = '0;
    sat = 1'b0;
    if (cmd == START[0]) begin
      pr_meas = 1'b1;
      pr_count = '0;
    end else if (pr_meas) begin
      if (sense) begin
        b.done = 1'b1;
      end else begin
        if (pr_count != CNT_MAX) pr_count = pr_count + 1'b1;
        if (32'(pr_count) >= shadow[REG_TIMEOUT]) begin
          b.done = 1'b1;
          b.tmo = 1'b1;
        end
      end
      if (b.done) begin
        pr_meas = 1'b0;
        pr_temp = temp_of_count(pr_count, sat);
      end
    end
    b.drive = pr_meas;
    b.elapsed = pr_count;
    b.temp = pr_temp;
    b.oor = sat;
    return b;
  endfunction

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    shadow[idx] = value & ((32'd1 << reg_width[idx]) - 1);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_all(input logic [31:0] v [8]);
    drain();
    for (int i = 0; i < 8; i++) apb_write(reg_idx_e'(i), v[i]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_beat(input logic cmd, input logic sense, input meas_beat_t exp_b,
                           input bit known);
    meas_beat_t p;
    p = step_thermistor(cmd, sense);
    pending_beats.push_back(known ? exp_b : p);
    if (src_gaps && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.command <= cmd;
    in_bus.sense_asserted <= sense;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic random_items(input int n, input int sense_odds);
    logic c, s;
    for (int k = 0; k < n; k++) begin
      if (!pr_meas) begin
        c = ($urandom_range(0, 9) == 0) ? TICK[0] : START[0];
        s = 1'($urandom);
      end else if ($urandom_range(0, 29) == 0) begin
        c = START[0];
        s = 1'($urandom);
      end else begin
        c = TICK[0];
        s = ($urandom_range(0, sense_odds - 1) == 0);
      end
      send_beat(c, s, '0, 1'b0);
    end
  endtask

  function automatic logic [31:0] rnd_bits(input int w);
    return $urandom & ((32'd1 << w) - 1);
  endfunction

  // sink: checks every beat and throttles ready
  initial begin
    meas_beat_t e, a;
    int hold;
    hold = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        a = '{out_bus.drive_asserted, out_bus.done_res, out_bus.timed_out,
              out_bus.elapsed_us, out_bus.temperature_tenths, out_bus.out_of_range};
        beats_seen++;
        if (a.done) dones_seen++;
        if (a.tmo) timeouts_seen++;
        if (a.oor) saturated_seen++;
        if (pending_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: %p", a);
        end else begin
          e = pending_beats.pop_front();
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp drive %0b done %0b tmo %0b us %0d t %0d oor %0b | got drive %0b done %0b tmo %0b us %0d t %0d oor %0b",
                       e.drive, e.done, e.tmo, e.elapsed, e.temp, e.oor,
                       a.drive, a.done, a.tmo, a.elapsed, a.temp, a.oor);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 400;
      end else if (hold == 0 && snk_stalls && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 19);
      end
      if (hold > 0) begin
        hold--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    steer_row_t steer [NSTEER];
    logic [31:0] v [8];
    int guard;
    steer = '{
      '{TICK[0],  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 21'd0, 12'sd0, 1'b0}},
      '{TICK[0],  1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 21'd0, 12'sd0, 1'b0}},
      '{START[0], 1'b1, 1'b1, '{1'b1, 1'b0, 1'b0, 21'd0, 12'sd0, 1'b0}},
      '{TICK[0],  1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 21'd1, 12'sd0, 1'b0}},
      '{TICK[0],  1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 21'd2, 12'sd0, 1'b0}},
      '{START[0], 1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 21'd0, 12'sd0, 1'b0}},
      '{TICK[0],  1'b0, 1'b1, '{1'b1, 1'b0, 1'b0, 21'd1, 12'sd0, 1'b0}},
      '{TICK[0],  1'b1, 1'b1, '{1'b0, 1'b1, 1'b0, 21'd1, 12'sd1500, 1'b1}},
      '{TICK[0],  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 21'd1, 12'sd1500, 1'b0}}
    };
    in_bus.valid <= 1'b0;
    in_bus.command <= 1'b0;
    in_bus.sense_asserted <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_ni <= 1'b0;
    build_log2_lut();
    shadow = '{500000, 76300, 218300, 2400, 7800, 10000, 4300, 298};
    pr_meas = 1'b0;
    pr_count = '0;
    pr_temp = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NSTEER; i++)
      send_beat(steer[i].cmd, steer[i].sense, steer[i].res, steer[i].known);
    random_items(15, 4);

    // realistic curve, short timeout; long sink hold-off to back up the input
    v = '{30, 0, 40, 2400, 7800, 10000, 4300, 298};
    set_all(v);
    hold_req = 1'b1;
    random_items(90, 12);

    // all-ones registers
    v = '{32'h1FFFFF, 32'h1FFFFF, 32'h1FFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h3FFF, 32'h1FF};
    set_all(v);
    random_items(40, 5);

    // all-zero registers: immediate timeout, degenerate divisors, zero denominator
    v = '{0, 0, 0, 0, 0, 0, 0, 0};
    set_all(v);
    random_items(40, 5);

    // single-tick timeout, low beta
    v = '{1, 0, 1, 100, 65535, 1, 1, 400};
    set_all(v);
    random_items(40, 5);

    for (int ph = 0; ph < 6; ph++) begin
      v[REG_TIMEOUT]  = $urandom_range(1, 60);
      v[REG_OFFSET]   = (ph % 2) ? rnd_bits(21) : $urandom_range(0, 60);
      v[REG_SPAN_US]  = (ph % 3 == 0) ? rnd_bits(21) : $urandom_range(1, 60);
      v[REG_BASE]     = rnd_bits(16);
      v[REG_SPAN_OHM] = rnd_bits(16);
      v[REG_NOM_OHM]  = rnd_bits(16);
      v[REG_BETA]     = (ph % 2) ? rnd_bits(14) : $urandom_range(1000, 6000);
      v[REG_NOM_K]    = (ph % 2) ? rnd_bits(9) : $urandom_range(200, 400);
      set_all(v);
      random_items(60, 10);
    end

    // calm tail
    src_gaps = 1'b0;
    snk_stalls = 1'b0;
    v = '{25, 10, 20, 3000, 9000, 10000, 3950, 298};
    set_all(v);
    random_items(60, 10);

    in_bus.valid <= 1'b0;
    guard = 0;
    while (pending_beats.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    if (pending_beats.size() != 0) mismatches++;
    $display("%0d beats sent, %0d checked; %0d measurements finished, %0d by timeout",
             items_sent, beats_seen, dones_seen, timeouts_seen);
    $display("%0d saturated results, %0d mismatches", saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
